// ===== src/h2r_pkg.sv =====
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the hsv to rgb converter
// Field widths, fixed-point constants and the hue sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

    // field widths
    localparam int HUE_W  = 16;
    localparam int CHAN_W = 16;
    localparam int FRAC_W = 16;
    localparam int LVL_W  = 7;

    // largest level that fits the output field
    localparam int LVL_MAX = (1 << LVL_W) - 1;

    // default full-scale output level
    localparam int OUT_MAX_DEF = 127;

    // fixed-point constants
    localparam logic [CHAN_W-1:0] ONE_Q15 = 16'h8000;
    localparam logic [FRAC_W:0]   ONE_Q16 = 17'h1_0000;
    localparam logic [31:0]       ONE_Q31 = 32'h8000_0000;

    // hue turn split into six sectors
    localparam int HUE_STEPS = 6;
    localparam int H6_W      = HUE_W + 3;

    // truncation shifts of the scaled levels
    localparam int V_SHIFT  = 15;
    localparam int P_SHIFT  = 30;
    localparam int QT_SHIFT = 46;

    // hue sector, named by the colors at its two ends
    typedef enum logic [2:0] {
        SEC_RED_YELLOW    = 3'd0,
        SEC_YELLOW_GREEN  = 3'd1,
        SEC_GREEN_CYAN    = 3'd2,
        SEC_CYAN_BLUE     = 3'd3,
        SEC_BLUE_MAGENTA  = 3'd4,
        SEC_MAGENTA_RED   = 3'd5
    } sector_t;

endpackage

// ===== src/h2r_hsv_if.sv =====
// ----------------------------------------------------------------------------
// h2r_hsv_if: hsv pixel stream
// Valid/ready channel carrying hue, saturation and brightness.
// ----------------------------------------------------------------------------
interface h2r_hsv_if;

    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::HUE_W-1:0]     hue;
    logic [h2r_pkg::CHAN_W-1:0]    saturation;
    logic [h2r_pkg::CHAN_W-1:0]    brightness;

    modport source
    (
        output valid,
        output hue,
        output saturation,
        output brightness,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  hue,
        input  saturation,
        input  brightness,
        output ready
    );

endinterface

// ===== src/h2r_rgb_if.sv =====
// ----------------------------------------------------------------------------
// h2r_rgb_if: rgb level stream
// Valid/ready channel carrying the three 7-bit channel levels.
// ----------------------------------------------------------------------------
interface h2r_rgb_if;

    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::LVL_W-1:0]     red_level;
    logic [h2r_pkg::LVL_W-1:0]     green_level;
    logic [h2r_pkg::LVL_W-1:0]     blue_level;

    modport source
    (
        output valid,
        output red_level,
        output green_level,
        output blue_level,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  red_level,
        input  green_level,
        input  blue_level,
        output ready
    );

endinterface

// ===== src/hsv_to_rgb_7bit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_7bit: hsv to rgb color conversion
// Four-stage pipeline turning one hsv pixel into three 7-bit levels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns its rgb levels from the output
// register; the depth is set by the two chained multiplies of the q and t
// levels (saturation times hue fraction, then value times the result), each
// followed by a register. The whole pipeline advances together: when a result
// sits in the output register and is not taken, every stage holds and the
// input is not ready. Brightness above 1.0 wraps down by 1.0, saturation above
// 1.0 is clipped to 1.0, and zero saturation gives grey through the general
// formulas. Levels are scaled by OUT_MAX and truncated to the 7-bit field.
module hsv_to_rgb_7bit
#(
    parameter int OUT_MAX = h2r_pkg::OUT_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    h2r_hsv_if.sink     hsv,
    h2r_rgb_if.source   rgb
);

    import h2r_pkg::*;

    // widths that follow from the output scale
    localparam int MAX_W = $clog2(OUT_MAX + 1);
    localparam int VM_W  = CHAN_W + MAX_W;
    localparam int VP_W  = VM_W + CHAN_W;
    localparam int VQ_W  = VM_W + 32;

    // pipeline enable: everything moves unless the output is held
    logic advance;
    assign advance   = !rgb.valid || rgb.ready;
    assign hsv.ready = advance;

    // ------------------------------------------------------------------
    // stage 1: clamp inputs, split hue, scale value
    // ------------------------------------------------------------------
    logic [CHAN_W-1:0] v_clamp;
    logic [CHAN_W-1:0] s_clamp;
    logic [H6_W-1:0]   hue6;

    always_comb
    begin
        v_clamp = (hsv.brightness > ONE_Q15) ? (hsv.brightness - ONE_Q15) : hsv.brightness;
        s_clamp = (hsv.saturation > ONE_Q15) ? ONE_Q15 : hsv.saturation;
        hue6    = H6_W'(hsv.hue) * H6_W'(HUE_STEPS);
    end

    logic              val1_reg;
    logic [CHAN_W-1:0] v1_reg;
    logic [CHAN_W-1:0] s1_reg;
    logic [CHAN_W-1:0] ps1_reg;
    logic [FRAC_W-1:0] f1_reg;
    sector_t           sec1_reg;
    logic [VM_W-1:0]   vm1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val1_reg <= 1'b0;
        end
        else if (advance)
        begin
            val1_reg <= hsv.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            v1_reg   <= v_clamp;
            s1_reg   <= s_clamp;
            ps1_reg  <= ONE_Q15 - s_clamp;
            f1_reg   <= hue6[FRAC_W-1:0];
            sec1_reg <= sector_t'(hue6[H6_W-1:FRAC_W]);
            vm1_reg  <= VM_W'(v_clamp) * VM_W'(OUT_MAX);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: saturation times fraction and (1 - f), value times (1 - s)
    // ------------------------------------------------------------------
    logic [FRAC_W:0] w_frac;
    assign w_frac = ONE_Q16 - {1'b0, f1_reg};

    logic            val2_reg;
    logic [31:0]     sf2_reg;
    logic [31:0]     sw2_reg;
    logic [VP_W-1:0] vp2_reg;
    logic [VM_W-1:0] vm2_reg;
    sector_t         sec2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val2_reg <= 1'b0;
        end
        else if (advance)
        begin
            val2_reg <= val1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sf2_reg  <= 32'(s1_reg) * 32'(f1_reg);
            sw2_reg  <= 32'(33'(s1_reg) * 33'(w_frac));
            vp2_reg  <= VP_W'(vm1_reg) * VP_W'(ps1_reg);
            vm2_reg  <= vm1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: value times (1 - s*f) and (1 - s*(1-f)), truncate p and v
    // ------------------------------------------------------------------
    logic [31:0] inner_q;
    logic [31:0] inner_t;
    assign inner_q = ONE_Q31 - sf2_reg;
    assign inner_t = ONE_Q31 - sw2_reg;

    logic             val3_reg;
    logic [VQ_W-1:0]  vq3_reg;
    logic [VQ_W-1:0]  vt3_reg;
    logic [LVL_W-1:0] lp3_reg;
    logic [LVL_W-1:0] lv3_reg;
    sector_t          sec3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val3_reg <= 1'b0;
        end
        else if (advance)
        begin
            val3_reg <= val2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vq3_reg  <= VQ_W'(vm2_reg) * VQ_W'(inner_q);
            vt3_reg  <= VQ_W'(vm2_reg) * VQ_W'(inner_t);
            lp3_reg  <= LVL_W'(vp2_reg >> P_SHIFT);
            lv3_reg  <= LVL_W'(vm2_reg >> V_SHIFT);
            sec3_reg <= sec2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: truncate q and t, pick channels by sector
    // ------------------------------------------------------------------
    logic [LVL_W-1:0] lq;
    logic [LVL_W-1:0] lt;
    logic [LVL_W-1:0] red_next;
    logic [LVL_W-1:0] green_next;
    logic [LVL_W-1:0] blue_next;

    always_comb
    begin
        lq = LVL_W'(vq3_reg >> QT_SHIFT);
        lt = LVL_W'(vt3_reg >> QT_SHIFT);
        case (sec3_reg)
            SEC_RED_YELLOW:
            begin
                red_next = lv3_reg; green_next = lt;      blue_next = lp3_reg;
            end
            SEC_YELLOW_GREEN:
            begin
                red_next = lq;      green_next = lv3_reg; blue_next = lp3_reg;
            end
            SEC_GREEN_CYAN:
            begin
                red_next = lp3_reg; green_next = lv3_reg; blue_next = lt;
            end
            SEC_CYAN_BLUE:
            begin
                red_next = lp3_reg; green_next = lq;      blue_next = lv3_reg;
            end
            SEC_BLUE_MAGENTA:
            begin
                red_next = lt;      green_next = lp3_reg; blue_next = lv3_reg;
            end
            default:
            begin
                red_next = lv3_reg; green_next = lp3_reg; blue_next = lq;
            end
        endcase
    end

    logic             out_val_reg;
    logic [LVL_W-1:0] red_reg;
    logic [LVL_W-1:0] green_reg;
    logic [LVL_W-1:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_val_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_val_reg <= val3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // output channel
    assign rgb.valid       = out_val_reg;
    assign rgb.red_level   = red_reg;
    assign rgb.green_level = green_reg;
    assign rgb.blue_level  = blue_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // an accepted pixel always lands in stage 1
    assert property (@(posedge clk) disable iff (!rst_n)
        (hsv.valid && hsv.ready) |=> val1_reg)
    else $error("accepted pixel missing from stage 1");

    // clamping keeps value and saturation within 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        val1_reg |-> ((v1_reg <= ONE_Q15) && (s1_reg <= ONE_Q15)))
    else $error("stage 1 value or saturation above 1.0");

    // a held result stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && !rgb.ready) |-> !hsv.ready)
    else $error("input ready while output stalled");

    // levels never exceed the scale when it fits the field
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb.valid |-> ((OUT_MAX > LVL_MAX) ||
                       ((int'(rgb.red_level) <= OUT_MAX) &&
                        (int'(rgb.green_level) <= OUT_MAX) &&
                        (int'(rgb.blue_level) <= OUT_MAX))))
    else $error("output level above full scale");

endmodule
